// ===== rtl/assert_macros.svh =====
// Assertion macros used by the back end RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that an expression holds at every clock edge out of reset.
`define AST_CHECK(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define AST_IMPLY(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");
`else
`define AST_CHECK(lbl, expr)
`define AST_IMPLY(lbl, cond, cons)
`endif
`endif

// ===== rtl/dfs_pkg.sv =====
// Package: sizes, codes and the command type of the field substitution unit.
`timescale 1ns / 1ps
`default_nettype none
package dfs_pkg;
  localparam int ENTRY_MAX   = 16;
  localparam int NAME_LEN    = 20;
  localparam int CONTENT_LEN = 40;
  localparam int RAW_MAX     = 32;

  localparam int ENTRY_W = 4;
  localparam int NAME_AW = 9;   // 320 name bytes
  localparam int CONT_AW = 10;  // 640 content bytes
  localparam int KEY_IW  = 5;   // key buffer index / length
  localparam int POS_W   = 6;
  localparam int RAW_IW  = 5;
  localparam int RAW_CW  = 6;
  localparam int CLR_W   = 10;
  localparam int CNT_W   = 5;

  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [1:0] OP_NAME = 2'd0;
  localparam logic [1:0] OP_CONT = 2'd1;
  localparam logic [1:0] OP_TEXT = 2'd2;
  localparam logic [1:0] OP_END  = 2'd3;

  localparam logic [1:0] K_NAME = 2'd0;
  localparam logic [1:0] K_CONT = 2'd1;
  localparam logic [1:0] K_TEXT = 2'd2;
  localparam logic [1:0] K_END  = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ENTRY_W-1:0] entry;
    logic [POS_W-1:0]   position;
    logic [7:0]         data_byte;
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/dfs_if.sv =====
// Interfaces: input word, result word and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface dfs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [3:0] entry;
  logic [5:0] position;
  logic [7:0] data_byte;
  modport source (output valid, operation, entry, position, data_byte, input ready);
  modport sink (input valid, operation, entry, position, data_byte, output ready);
endinterface

interface dfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_marker;
  logic       truncated;
  modport source (output valid, out_byte, end_marker, truncated, input ready);
  modport sink (input valid, out_byte, end_marker, truncated, output ready);
endinterface

interface dfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] entry_count;
  modport source (output valid, entry_count, input ready);
  modport sink (input valid, entry_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/dfs_front.sv =====
// Front end: classifies input words and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module dfs_front
  import dfs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  dfs_in_if.sink    items,
  output cmd_t      head,
  output logic      head_valid,
  input  wire logic head_ready
);
  cmd_t       q0, q1, cmd;
  logic [1:0] count;
  logic       keep, push, pop;

  always_comb begin
    cmd.entry     = items.entry;
    cmd.position  = items.position;
    cmd.data_byte = items.data_byte;
    keep          = 1'b1;
    unique case (items.operation)
      OP_NAME: begin
        cmd.kind = K_NAME;
        keep     = items.position < POS_W'(NAME_LEN);
      end
      OP_CONT: begin
        cmd.kind = K_CONT;
        keep     = items.position < POS_W'(CONTENT_LEN);
      end
      OP_TEXT: cmd.kind = (items.data_byte == 8'd0) ? K_END : K_TEXT;
      default: cmd.kind = K_END;
    endcase
  end

  assign items.ready = (count != 2'd2);
  assign push        = items.valid && items.ready && keep;
  assign head        = q0;
  assign head_valid  = (count != 2'd0);
  assign pop         = head_valid && head_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // two-entry queue, head in q0
  always_ff @(posedge clk) begin
    if (pop && push) begin
      if (count == 2'd1) begin
        q0 <= cmd;
      end else begin
        q0 <= q1;
        q1 <= cmd;
      end
    end else if (pop) begin
      q0 <= q1;
    end else if (push) begin
      if (count == 2'd0) begin
        q0 <= cmd;
      end else begin
        q1 <= cmd;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/dfs_back.sv =====
// Back end: tables, token state, search, expansion and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dfs_back
  import dfs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_t      head,
  input  wire logic head_valid,
  output logic      head_ready,
  dfs_cfg_if.sink   cfg,
  dfs_out_if.source results
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_NREAD = 4'd2;
  localparam logic [3:0] S_NCMP  = 4'd3;
  localparam logic [3:0] S_CREAD = 4'd4;
  localparam logic [3:0] S_CEMIT = 4'd5;
  localparam logic [3:0] S_AMP   = 4'd6;
  localparam logic [3:0] S_RAW   = 4'd7;
  localparam logic [3:0] S_END   = 4'd8;

  logic [3:0]        state;
  logic [CLR_W-1:0]  clr;
  logic              in_token;
  logic [7:0]        key [NAME_LEN];
  logic [KEY_IW-1:0] key_len;
  logic              key_long;
  logic [7:0]        raw [RAW_MAX];
  logic [RAW_CW-1:0] raw_cnt;
  logic              raw_ovf;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  e;
  logic [POS_W-1:0]  p;
  logic              ovalid;
  logic [7:0]        obyte;
  logic              oend, otrunc;

  logic [7:0] name_mem [ENTRY_MAX*NAME_LEN];
  logic [7:0] cont_mem [ENTRY_MAX*CONTENT_LEN];
  logic [7:0] name_q, cont_q;
  logic [NAME_AW-1:0] name_ra, name_wa;
  logic [CONT_AW-1:0] cont_ra, cont_wa;
  logic       name_we, cont_we;

  logic             out_free, take;
  logic [CNT_W-1:0] limit;
  logic [7:0]       kb;
  logic [CNT_W-1:0] e_inc;

  assign out_free = !ovalid || results.ready;
  assign limit    = (entry_count > CNT_W'(ENTRY_MAX)) ? CNT_W'(ENTRY_MAX) : entry_count;
  assign kb       = (KEY_IW'(p) < key_len) ? key[p[KEY_IW-1:0]] : 8'd0;
  assign e_inc    = e + CNT_W'(1);

  // pass-through text needs the result register free
  always_comb begin
    head_ready = 1'b0;
    if (state == S_IDLE && head_valid) begin
      head_ready = !(head.kind == K_TEXT && !in_token && head.data_byte != CHAR_AMP)
                   || out_free;
    end
  end
  assign take = head_valid && head_ready;

  always_comb begin
    name_ra = NAME_AW'(e[ENTRY_W-1:0]) * NAME_AW'(NAME_LEN) + NAME_AW'(p);
    cont_ra = CONT_AW'(e[ENTRY_W-1:0]) * CONT_AW'(CONTENT_LEN) + CONT_AW'(p);
    if (state == S_CLEAR) begin
      name_we = clr < CLR_W'(ENTRY_MAX*NAME_LEN);
      cont_we = 1'b1;
      name_wa = clr[NAME_AW-1:0];
      cont_wa = clr;
    end else begin
      name_we = take && head.kind == K_NAME;
      cont_we = take && head.kind == K_CONT;
      name_wa = NAME_AW'(head.entry) * NAME_AW'(NAME_LEN) + NAME_AW'(head.position);
      cont_wa = CONT_AW'(head.entry) * CONT_AW'(CONTENT_LEN) + CONT_AW'(head.position);
    end
  end

  always_ff @(posedge clk) begin
    if (name_we) begin
      name_mem[name_wa] <= (state == S_CLEAR) ? 8'd0 : head.data_byte;
    end
    name_q <= name_mem[name_ra];
  end

  always_ff @(posedge clk) begin
    if (cont_we) begin
      cont_mem[cont_wa] <= (state == S_CLEAR) ? 8'd0 : head.data_byte;
    end
    cont_q <= cont_mem[cont_ra];
  end

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg.valid) begin
      entry_count <= cfg.entry_count;
    end
  end

  // raw and key buffers: payload only, gated by their counts; the key skips control bytes
  always_ff @(posedge clk) begin
    if (state == S_IDLE && take && head.kind == K_TEXT && in_token
        && head.data_byte != CHAR_AMP) begin
      if (raw_cnt < RAW_CW'(RAW_MAX)) begin
        raw[raw_cnt[RAW_IW-1:0]] <= head.data_byte;
      end
      if (head.data_byte >= CHAR_SPACE && key_len < KEY_IW'(NAME_LEN-1)) begin
        key[key_len] <= head.data_byte;
      end
    end
  end

  assign results.valid      = ovalid;
  assign results.out_byte   = obyte;
  assign results.end_marker = oend;
  assign results.truncated  = otrunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      in_token <= 1'b0;
      key_len  <= '0;
      key_long <= 1'b0;
      raw_cnt  <= '0;
      raw_ovf  <= 1'b0;
      e        <= '0;
      p        <= '0;
      ovalid   <= 1'b0;
    end else begin
      if (results.ready) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + CLR_W'(1);
          if (clr == CLR_W'(ENTRY_MAX*CONTENT_LEN-1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            case (head.kind)
              K_END: state <= in_token ? S_AMP : S_END;
              K_TEXT: begin
                if (!in_token) begin
                  if (head.data_byte == CHAR_AMP) begin
                    in_token <= 1'b1;
                    key_len  <= '0;
                    key_long <= 1'b0;
                    raw_cnt  <= '0;
                    raw_ovf  <= 1'b0;
                  end else begin
                    ovalid <= 1'b1;
                    obyte  <= head.data_byte;
                    oend   <= 1'b0;
                    otrunc <= 1'b0;
                  end
                end else if (head.data_byte == CHAR_AMP) begin
                  if (key_long || limit == '0) begin
                    in_token <= 1'b0;
                    key_len  <= '0;
                    raw_cnt  <= '0;
                    raw_ovf  <= 1'b0;
                  end else begin
                    e     <= '0;
                    p     <= '0;
                    state <= S_NREAD;
                  end
                end else begin
                  if (raw_cnt < RAW_CW'(RAW_MAX)) begin
                    raw_cnt <= raw_cnt + RAW_CW'(1);
                  end else begin
                    raw_ovf <= 1'b1;
                  end
                  if (head.data_byte >= CHAR_SPACE) begin
                    if (key_len < KEY_IW'(NAME_LEN-1)) begin
                      key_len <= key_len + KEY_IW'(1);
                    end else begin
                      key_long <= 1'b1;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_NREAD: state <= S_NCMP;
        S_NCMP: begin
          if (kb != name_q || (kb != 8'd0 && p == POS_W'(NAME_LEN-1))) begin
            // no match on this entry
            p <= '0;
            e <= e_inc;
            if (e_inc >= limit) begin
              in_token <= 1'b0;
              key_len  <= '0;
              raw_cnt  <= '0;
              raw_ovf  <= 1'b0;
              state    <= S_IDLE;
            end else begin
              state <= S_NREAD;
            end
          end else if (kb == 8'd0) begin
            p     <= '0;
            state <= S_CREAD;
          end else begin
            p     <= p + POS_W'(1);
            state <= S_NREAD;
          end
        end
        S_CREAD: state <= S_CEMIT;
        S_CEMIT: begin
          if (cont_q == 8'd0) begin
            in_token <= 1'b0;
            key_len  <= '0;
            raw_cnt  <= '0;
            raw_ovf  <= 1'b0;
            state    <= S_IDLE;
          end else if (out_free) begin
            ovalid <= 1'b1;
            obyte  <= cont_q;
            oend   <= 1'b0;
            otrunc <= 1'b0;
            if (p == POS_W'(CONTENT_LEN-2)) begin
              in_token <= 1'b0;
              key_len  <= '0;
              raw_cnt  <= '0;
              raw_ovf  <= 1'b0;
              state    <= S_IDLE;
            end else begin
              p     <= p + POS_W'(1);
              state <= S_CREAD;
            end
          end
        end
        S_AMP: begin
          if (out_free) begin
            ovalid <= 1'b1;
            obyte  <= CHAR_AMP;
            oend   <= 1'b0;
            otrunc <= 1'b0;
            p      <= '0;
            state  <= (raw_cnt == '0) ? S_END : S_RAW;
          end
        end
        S_RAW: begin
          if (out_free) begin
            ovalid <= 1'b1;
            obyte  <= raw[p[RAW_IW-1:0]];
            oend   <= 1'b0;
            otrunc <= 1'b0;
            p      <= p + POS_W'(1);
            if (RAW_CW'(p) + RAW_CW'(1) == raw_cnt) begin
              state <= S_END;
            end
          end
        end
        S_END: begin
          if (out_free) begin
            ovalid   <= 1'b1;
            obyte    <= 8'd0;
            oend     <= 1'b1;
            otrunc   <= raw_ovf;
            in_token <= 1'b0;
            key_len  <= '0;
            key_long <= 1'b0;
            raw_cnt  <= '0;
            raw_ovf  <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AST_IMPLY(a_trunc_on_end, results.valid && results.truncated, results.end_marker)
  `AST_IMPLY(a_no_take_in_clear, state == S_CLEAR, !head_ready)
  `AST_IMPLY(a_raw_ovf_full, raw_ovf, raw_cnt == RAW_CW'(RAW_MAX))
  `AST_CHECK(a_key_bound, key_len < KEY_IW'(NAME_LEN))
endmodule
`default_nettype wire

// ===== rtl/delimited_field_substitution_unit.sv =====
// Top level: delimited field substitution unit.
// Flow: a plain text byte waits in the two-entry input queue, then shows on the result port
// in the cycle after it is taken. Expansion reads and compares each name byte per entry
// (NREAD, NCMP), then emits each content byte (CREAD, CEMIT); unclosed-token dump emits raw bytes.
// Throughput: one text byte per cycle outside tokens unless the result register stalls.
// Reset: synchronous, clears control; then a pass that zeroes both tables blocks input.
`timescale 1ns / 1ps
`default_nettype none
module delimited_field_substitution_unit
  import dfs_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  dfs_in_if.sink    items,
  dfs_cfg_if.sink   cfg,
  dfs_out_if.source results
);
  // word queue between classifier and executor
  cmd_t head;
  logic head_valid;
  logic head_ready;

  // front: classify words, drop out-of-range loads, buffer two words
  dfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .head       (head),
    .head_valid (head_valid),
    .head_ready (head_ready)
  );

  // back: tables, token tracking, name search and result emission
  dfs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_ready (head_ready),
    .cfg        (cfg),
    .results    (results)
  );
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the delimited field substitution unit: table stimulus, random text, predictor.
`timescale 1ns / 1ps
module tb_top;
  import dfs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dfs_in_if  items();
  dfs_cfg_if cfg();
  dfs_out_if results();

  delimited_field_substitution_unit DUT (
    .clk(clk), .rst(rst), .items(items), .cfg(cfg), .results(results)
  );

  // One expected result word.
  typedef struct packed {
    logic [7:0] ob;
    logic       em;
    logic       tr;
  } res_t;

  // Predictor state: tables, token tracking, entry count.
  logic [7:0] names [ENTRY_MAX][NAME_LEN];
  logic [7:0] conts [ENTRY_MAX][CONTENT_LEN];
  logic [4:0] n_entries;
  bit         in_tok;
  logic [7:0] key [NAME_LEN];
  int         key_len;
  bit         key_long;
  logic [7:0] raw [RAW_MAX];
  int         raw_cnt;
  bit         raw_ovf;

  res_t pending_words[$];
  int   errors = 0;
  int   words_seen = 0;
  int   words_pushed = 0;
  int   texts_seen = 0;
  int   items_sent = 0;
  longint cycles = 0;

  // entry counts used by the random phases
  logic [4:0] phase_counts [6] = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd8, 5'd17};

  function automatic void tok_clear();
    in_tok = 0;
    foreach (key[i]) key[i] = 8'h00;
    key_len = 0;
    key_long = 0;
    raw_cnt = 0;
    raw_ovf = 0;
  endfunction

  function automatic void push_word(logic [7:0] b, logic e, logic t);
    res_t r;
    r.ob = b;
    r.em = e;
    r.tr = t;
    pending_words.push_back(r);
    words_pushed++;
  endfunction

  // Key vs. stored name, up to the name's first zero byte.
  function automatic bit name_hit(int e);
    logic [7:0] kb, nb;
    for (int p = 0; p < NAME_LEN; p++) begin
      kb = (p < key_len) ? key[p] : 8'h00;
      nb = names[e][p];
      if (kb != nb) return 0;
      if (kb == 8'h00) return 1;
    end
    return 0;
  endfunction

  function automatic void substitute_key();
    int lim;
    lim = (n_entries > ENTRY_MAX) ? ENTRY_MAX : n_entries;
    if (key_long) return;
    for (int e = 0; e < lim; e++) begin
      if (name_hit(e)) begin
        for (int p = 0; p + 1 < CONTENT_LEN; p++) begin
          if (conts[e][p] == 8'h00) break;
          push_word(conts[e][p], 1'b0, 1'b0);
        end
        return;
      end
    end
  endfunction

  // Works out the result words caused by one input word.
  function automatic void predict_text(logic [1:0] op, logic [3:0] ent,
                                       logic [5:0] pos, logic [7:0] b);
    logic t;
    if (op == OP_NAME) begin
      if (pos < NAME_LEN) names[ent][pos] = b;
      return;
    end
    if (op == OP_CONT) begin
      if (pos < CONTENT_LEN) conts[ent][pos] = b;
      return;
    end
    if (op == OP_END || b == 8'h00) begin
      t = 1'b0;
      if (in_tok) begin
        push_word(CHAR_AMP, 1'b0, 1'b0);
        for (int i = 0; i < raw_cnt; i++) push_word(raw[i], 1'b0, 1'b0);
        t = raw_ovf;
      end
      push_word(8'h00, 1'b1, t);
      tok_clear();
      return;
    end
    if (!in_tok) begin
      if (b == CHAR_AMP) begin
        tok_clear();
        in_tok = 1;
      end else begin
        push_word(b, 1'b0, 1'b0);
      end
      return;
    end
    if (b == CHAR_AMP) begin
      substitute_key();
      tok_clear();
      return;
    end
    if (raw_cnt < RAW_MAX) begin
      raw[raw_cnt] = b;
      raw_cnt++;
    end else begin
      raw_ovf = 1;
    end
    if (b >= CHAR_SPACE) begin
      if (key_len + 1 < NAME_LEN) begin
        key[key_len] = b;
        key_len++;
      end else begin
        key_long = 1;
      end
    end
  endfunction

  // Receiver: random stall pattern, compare against oldest expectation.
  int stall_mode = 0;
  always @(posedge clk) begin
    res_t exp_w;
    cycles <= cycles + 1;
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        words_seen++;
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word byte=%h end=%b trunc=%b", $time,
                   results.out_byte, results.end_marker, results.truncated);
          errors++;
        end else begin
          exp_w = pending_words.pop_front();
          if (results.end_marker) texts_seen++;
          if (exp_w.ob !== results.out_byte || exp_w.em !== results.end_marker ||
              exp_w.tr !== results.truncated) begin
            $display("%0t: mismatch expected byte=%h end=%b trunc=%b, got %h %b %b",
                     $time, exp_w.ob, exp_w.em, exp_w.tr,
                     results.out_byte, results.end_marker, results.truncated);
            errors++;
          end
        end
      end
      // stall pattern: mode 0 always ready, 1 light stalls, 2 heavy stalls
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: results.ready <= 1'b1;
        1: results.ready <= ($urandom_range(0, 3) != 0);
        default: results.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Limit: watchdog on cycles.
  localparam longint CYCLE_LIMIT = 5000000;
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL delimited_field_substitution_unit");
      $finish;
    end
  end

  // Sender: one word, with burst/gap idling.
  int burst_left = 0;
  task automatic send_word(logic [1:0] op, logic [3:0] ent, logic [5:0] pos,
                           logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        items.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    items.valid     <= 1'b1;
    items.operation <= op;
    items.entry     <= ent;
    items.position  <= pos;
    items.data_byte <= b;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    predict_text(op, ent, pos, b);
    items_sent++;
  endtask

  task automatic idle_inputs();
    items.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    idle_inputs();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_entry_count(logic [4:0] v);
    cfg.valid       <= 1'b1;
    cfg.entry_count <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    n_entries = v;
  endtask

  task automatic load_string(bit is_name, int e, string s);
    for (int i = 0; i < s.len(); i++)
      send_word(is_name ? OP_NAME : OP_CONT, e[3:0], i[5:0], s[i]);
    send_word(is_name ? OP_NAME : OP_CONT, e[3:0], 6'(s.len()), 8'h00);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_TEXT, 4'd0, 6'd0, s[i]);
  endtask

  // Directed table: op, entry, position, byte; expected word typed where obvious.
  typedef struct {
    logic [1:0] op;
    logic [3:0] ent;
    logic [5:0] pos;
    logic [7:0] b;
    bit         chk;
    logic [7:0] xb;
    logic       xe;
    logic       xt;
  } row_t;

  row_t rows[] = '{
    '{OP_TEXT, 4'd0, 6'd0, 8'hFF, 1, 8'hFF, 1'b0, 1'b0},  // high byte passes
    '{OP_TEXT, 4'd15, 6'd63, 8'h01, 1, 8'h01, 1'b0, 1'b0}, // control byte outside token
    '{OP_END,  4'd0, 6'd0, 8'h41, 1, 8'h00, 1'b1, 1'b0},  // end of text
    '{OP_TEXT, 4'd0, 6'd0, 8'h00, 1, 8'h00, 1'b1, 1'b0},  // zero text byte ends text
    '{OP_NAME, 4'd15, 6'd63, 8'hAA, 0, 8'h00, 1'b0, 1'b0}, // position out of range
    '{OP_CONT, 4'd15, 6'd40, 8'h55, 0, 8'h00, 1'b0, 1'b0}, // position out of range
    '{OP_NAME, 4'd0, 6'd0, 8'h41, 0, 8'h00, 1'b0, 1'b0},
    '{OP_CONT, 4'd0, 6'd0, 8'h7A, 0, 8'h00, 1'b0, 1'b0},
    '{OP_CONT, 4'd0, 6'd39, 8'hFF, 0, 8'h00, 1'b0, 1'b0}, // last content byte never shown
    '{OP_TEXT, 4'd0, 6'd0, CHAR_AMP, 0, 8'h00, 1'b0, 1'b0},
    '{OP_TEXT, 4'd0, 6'd0, 8'h41, 0, 8'h00, 1'b0, 1'b0},
    '{OP_TEXT, 4'd0, 6'd0, 8'h0A, 0, 8'h00, 1'b0, 1'b0},  // control byte dropped from key
    '{OP_TEXT, 4'd0, 6'd0, CHAR_AMP, 0, 8'h00, 1'b0, 1'b0}, // count 0: nothing
    '{OP_TEXT, 4'd0, 6'd0, CHAR_AMP, 0, 8'h00, 1'b0, 1'b0},
    '{OP_TEXT, 4'd0, 6'd0, 8'h80, 0, 8'h00, 1'b0, 1'b0},
    '{OP_END,  4'd0, 6'd0, 8'h00, 0, 8'h00, 1'b0, 1'b0}   // unclosed token dump
  };

  // the receiver pops concurrently, so rows are checked on the newest expectation
  task automatic run_rows();
    int base;
    for (int i = 0; i < rows.size(); i++) begin
      base = words_pushed;
      send_word(rows[i].op, rows[i].ent, rows[i].pos, rows[i].b);
      if (rows[i].chk) begin
        if (words_pushed != base + 1 ||
            pending_words[$] !== res_t'{rows[i].xb, rows[i].xe, rows[i].xt}) begin
          $display("%0t: table row %0d expected %h %b %b, predictor disagrees", $time,
                   i, rows[i].xb, rows[i].xe, rows[i].xt);
          errors++;
        end
      end
    end
  endtask

  string key_pool[6] = '{"A", "NAME", "", "x y", "LONGNAME_ABCDEFGHIJK", "\x90Q"};

  function automatic string rand_str(int maxlen);
    string s;
    int n;
    s = "";
    n = $urandom_range(0, maxlen);
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(33, 125)))};
    return s;
  endfunction

  function automatic logic [7:0] rand_text_byte();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 8'($urandom_range(1, 31));
    if (k == 1) return 8'($urandom_range(128, 255));
    if (k == 2) return CHAR_AMP;
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic string names_str(int e);
    string s;
    s = "";
    for (int p = 0; p < NAME_LEN && names[e][p] != 8'h00; p++)
      s = {s, string'(byte'(names[e][p]))};
    return s;
  endfunction

  // One random text: mostly well-formed tokens, some noise and broken ones.
  task automatic random_text();
    int parts;
    int k;
    string s;
    parts = $urandom_range(1, 5);
    for (int p = 0; p < parts; p++) begin
      k = $urandom_range(0, 9);
      if (k < 5) begin
        s = (k < 3) ? key_pool[$urandom_range(0, 5)] : names_str($urandom_range(0, 15));
        send_word(OP_TEXT, 4'd0, 6'd0, CHAR_AMP);
        send_text(s);
        if ($urandom_range(0, 3) == 0) send_word(OP_TEXT, 4'd0, 6'd0, 8'h09);
        send_word(OP_TEXT, 4'd0, 6'd0, CHAR_AMP);
      end else if (k < 8) begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          send_word(OP_TEXT, 4'($urandom), 6'($urandom), rand_text_byte());
      end else begin
        // open token, occasionally past the raw buffer
        send_word(OP_TEXT, 4'd0, 6'd0, CHAR_AMP);
        for (int i = ($urandom_range(0, 3) == 0) ? 36 : $urandom_range(0, 8); i > 0; i--)
          send_word(OP_TEXT, 4'd0, 6'd0, 8'($urandom_range(1, 255)) == CHAR_AMP ?
                    8'h21 : 8'($urandom_range(1, 255)));
        break;
      end
    end
    send_word($urandom_range(0, 1) ? OP_END : OP_TEXT, 4'($urandom), 6'($urandom),
              8'h00);
  endtask

  task automatic random_loads();
    int e;
    for (int j = $urandom_range(2, 6); j > 0; j--) begin
      e = $urandom_range(0, 15);
      load_string(1, e, ($urandom_range(0, 1)) ? key_pool[$urandom_range(0, 5)] : rand_str(6));
      load_string(0, e, rand_str(($urandom_range(0, 5) == 0) ? 45 : 8));
    end
  endtask

  initial begin
    items.valid = 1'b0;
    items.operation = OP_TEXT;
    items.entry = '0;
    items.position = '0;
    items.data_byte = '0;
    cfg.valid = 1'b0;
    cfg.entry_count = '0;
    foreach (names[e, p]) names[e][p] = 8'h00;
    foreach (conts[e, p]) conts[e][p] = 8'h00;
    foreach (raw[i]) raw[i] = 8'h00;
    n_entries = 0;
    tok_clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    run_rows();
    drain();
    set_entry_count(5'd1);
    send_text("&A&");                      // matched key, content "z"
    send_word(OP_TEXT, 4'd0, 6'd0, CHAR_AMP);
    send_text("ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789"); // raw overflow, long key
    send_word(OP_END, 4'd0, 6'd0, 8'h00);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      set_entry_count(phase_counts[phase]);
      while (items_sent < 72 * (phase + 1) + 60) begin
        if ($urandom_range(0, 3) == 0) random_loads();
        random_text();
      end
      drain();  // sender pauses until all results are in, then config changes
    end

    $display("Sent %0d input words; checked %0d result words over %0d texts.",
             items_sent, words_seen, texts_seen);
    if (errors == 0) begin
      $display("PASS delimited_field_substitution_unit");
    end else begin
      $display("FAIL delimited_field_substitution_unit");
    end
    $finish;
  end
endmodule
